// ----- hdl/keyed_table_upsert_best_select_top_assert.svh -----
// Assertion macros shared by the controller and top-level RTL files.
`ifndef KEYED_TABLE_UPSERT_BEST_SELECT_TOP_ASSERT_SVH
`define KEYED_TABLE_UPSERT_BEST_SELECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define KTUBS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define KTUBS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTUBS_ASSERT(name, clk, rst, prop, msg)
`define KTUBS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- hdl/ktubs_pkg.sv -----
package ktubs_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_BYTES = 8;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [63:0] KEY_MASK = 64'(~64'd0 >> (64 - 8 * KEY_BYTES));

  localparam logic MODE_UPSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic start;   // latch a new item, clear scan results
    logic step;    // read the next entry
    logic commit;  // update table, load result register
  } ktubs_cmd_t;

  typedef struct packed {
    logic idx_done;  // every held entry has been read
    logic rd_pend;   // read data is in flight
  } ktubs_sts_t;

endpackage

// ----- hdl/ktubs_ctrl.sv -----
`include "keyed_table_upsert_best_select_top_assert.svh"

module ktubs_ctrl
  import ktubs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ktubs_sts_t sts,
  output ktubs_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = !sts.idx_done;
        if (sts.idx_done && !sts.rd_pend) state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register can take the transaction
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `KTUBS_ASSERT(a_rd_only_in_scan, clk, rst, sts.rd_pend |-> (state == S_SCAN), "read data outside scan")
  `KTUBS_ASSERT(a_commit_shows, clk, rst, cmd.commit |=> out_valid, "commit without result")
  `KTUBS_ASSERT(a_no_step_past_end, clk, rst, cmd.step |-> !sts.idx_done, "read past held entries")

endmodule

// ----- hdl/ktubs_dp.sv -----
module ktubs_dp
  import ktubs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ktubs_cmd_t       cmd,
  output ktubs_sts_t       sts,
  input  logic             mode,
  input  logic [63:0]      key,
  input  logic             enabled,
  input  logic [31:0]      priority_req,
  input  logic [63:0]      fingerprint,
  output logic [1:0]       status,
  output logic             found,
  output logic             found_enabled,
  output logic [31:0]      found_priority,
  output logic [63:0]      found_fingerprint,
  output logic [CNT_W-1:0] entry_count,
  output logic [63:0]      revision,
  output logic             best_valid,
  output logic [63:0]      best_key,
  output logic [31:0]      best_priority,
  output logic [63:0]      best_fingerprint
);

  typedef struct packed {
    logic [63:0] key;
    logic        en;
    logic [31:0] pri;
    logic [63:0] fp;
  } entry_t;

  entry_t mem [CAPACITY];
  entry_t mem_q;

  // control state
  logic [CNT_W-1:0] count;
  logic [63:0]      rev;
  logic             rd_pend;

  // item and scan registers
  logic             mode_r;
  logic [63:0]      key_r;
  logic             en_r;
  logic [31:0]      pri_r;
  logic [63:0]      fp_r;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             f_en;
  logic [31:0]      f_pri;
  logic [63:0]      f_fp;
  logic             have_best;
  logic [63:0]      b_key;
  logic [31:0]      b_pri;
  logic [63:0]      b_fp;

  // scan compare
  logic        match;
  logic        use_new;
  logic        e_en;
  logic [31:0] e_pri;
  logic [63:0] e_fp;
  logic        take;

  // commit logic
  logic             upsert_ok;
  logic             app_ok;
  logic             do_write;
  logic             new_take;
  logic [1:0]       status_c;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] count_next;
  logic [63:0]      rev_next;

  assign sts.idx_done = (idx == count);
  assign sts.rd_pend  = rd_pend;

  always_comb begin
    match   = rd_pend && (mem_q.key == key_r);
    use_new = match && (mode_r == MODE_UPSERT);
    e_en    = use_new ? en_r  : mem_q.en;
    e_pri   = use_new ? pri_r : mem_q.pri;
    e_fp    = use_new ? fp_r  : mem_q.fp;
    take    = rd_pend && e_en &&
              (!have_best || (e_pri > b_pri) || ((e_pri == b_pri) && (e_fp > b_fp)));
  end

  always_comb begin
    upsert_ok = (mode_r == MODE_UPSERT) && (key_r != 64'd0);
    app_ok    = upsert_ok && !hit && (count < CNT_W'(CAPACITY));
    do_write  = upsert_ok && (hit || app_ok);
    // an appended entry sits last, so it wins only when strictly better
    new_take  = app_ok && en_r &&
                (!have_best || (pri_r > b_pri) || ((pri_r == b_pri) && (fp_r > b_fp)));
    wr_idx    = hit ? hit_idx : count[IDX_W-1:0];
    priority if (mode_r == MODE_FIND) status_c = ST_OK;
    else if (key_r == 64'd0)          status_c = ST_EMPTY;
    else if (do_write)                status_c = ST_OK;
    else                              status_c = ST_FULL;
    count_next = app_ok ? count + CNT_W'(1) : count;
    rev_next   = (do_write && (rev != '1)) ? rev + 64'd1 : rev;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) mem_q <= mem[idx[IDX_W-1:0]];
    if (cmd.commit && do_write) mem[wr_idx] <= '{key: key_r, en: en_r, pri: pri_r, fp: fp_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rev     <= 64'd1;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.step;
      if (cmd.commit) begin
        count <= count_next;
        rev   <= rev_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r    <= mode;
      key_r     <= key & KEY_MASK;
      en_r      <= enabled;
      pri_r     <= priority_req;
      fp_r      <= fingerprint;
      idx       <= '0;
      hit       <= 1'b0;
      have_best <= 1'b0;
    end else begin
      if (cmd.step) begin
        idx    <= idx + CNT_W'(1);
        rd_idx <= idx[IDX_W-1:0];
      end
      if (match) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
        f_en    <= mem_q.en;
        f_pri   <= mem_q.pri;
        f_fp    <= mem_q.fp;
      end
      if (take) begin
        have_best <= 1'b1;
        b_key     <= mem_q.key;
        b_pri     <= e_pri;
        b_fp      <= e_fp;
      end
    end
    if (cmd.commit) begin
      status      <= status_c;
      entry_count <= count_next;
      revision    <= rev_next;
      if ((mode_r == MODE_FIND) && hit) begin
        found             <= 1'b1;
        found_enabled     <= f_en;
        found_priority    <= f_pri;
        found_fingerprint <= f_fp;
      end else begin
        found             <= 1'b0;
        found_enabled     <= 1'b0;
        found_priority    <= 32'd0;
        found_fingerprint <= 64'd0;
      end
      priority if (new_take) begin
        best_valid       <= 1'b1;
        best_key         <= key_r;
        best_priority    <= pri_r;
        best_fingerprint <= fp_r;
      end else if (have_best) begin
        best_valid       <= 1'b1;
        best_key         <= b_key;
        best_priority    <= b_pri;
        best_fingerprint <= b_fp;
      end else begin
        best_valid       <= 1'b0;
        best_key         <= 64'd0;
        best_priority    <= 32'd0;
        best_fingerprint <= 64'd0;
      end
    end
  end

endmodule

// ----- hdl/keyed_table_upsert_best_select_top.sv -----
// Each input transaction scans the held entries, one entry memory read per cycle, then
// commits once the result register is free; the result is registered.
// A new input transaction is accepted only after the previous one has committed.
// A waiting result does not block the next input transaction.
// Reset: synchronous; table empty, revision 1, no result pending; no clearing pass.
`include "keyed_table_upsert_best_select_top_assert.svh"

module keyed_table_upsert_best_select_top
  import ktubs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [63:0]      key,
  input  logic             enabled,
  input  logic [31:0]      priority_req,
  input  logic [63:0]      fingerprint,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             found,
  output logic             found_enabled,
  output logic [31:0]      found_priority,
  output logic [63:0]      found_fingerprint,
  output logic [CNT_W-1:0] entry_count,
  output logic [63:0]      revision,
  output logic             best_valid,
  output logic [63:0]      best_key,
  output logic [31:0]      best_priority,
  output logic [63:0]      best_fingerprint
);

  ktubs_cmd_t cmd;
  ktubs_sts_t sts;

  ktubs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ktubs_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .mode              (mode),
    .key               (key),
    .enabled           (enabled),
    .priority_req      (priority_req),
    .fingerprint       (fingerprint),
    .status            (status),
    .found             (found),
    .found_enabled     (found_enabled),
    .found_priority    (found_priority),
    .found_fingerprint (found_fingerprint),
    .entry_count       (entry_count),
    .revision          (revision),
    .best_valid        (best_valid),
    .best_key          (best_key),
    .best_priority     (best_priority),
    .best_fingerprint  (best_fingerprint)
  );

  `KTUBS_ASSERT(a_full_means_capacity, clk, rst, (out_valid && (status == ST_FULL)) |-> (entry_count == CNT_W'(CAPACITY)), "full status below capacity")
  `KTUBS_ASSERT(a_best_key_nonzero, clk, rst, (out_valid && best_valid) |-> (best_key != 64'd0), "best entry with empty key")

endmodule

// ----- tb/sv/keyed_table_upsert_best_select_top_tb.sv -----
`timescale 1ns / 100ps

module keyed_table_upsert_best_select_top_tb;
  import ktubs_pkg::*;

  localparam int RANDOM_OPS     = 450;
  localparam int POOL_SIZE      = 40;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_ERR_LINES  = 40;

  localparam logic [63:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] K_ONE  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] K_TOP  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] K_CFG  = 64'h0000_0000_0067_6663;

  typedef struct {
    logic        mode;
    logic [63:0] key;
    logic        enabled;
    logic [31:0] pri;
    logic [63:0] fp;
  } table_op_t;

  typedef struct {
    logic [1:0]       status;
    logic             found;
    logic             found_enabled;
    logic [31:0]      found_pri;
    logic [63:0]      found_fp;
    logic [CNT_W-1:0] entry_count;
    logic [63:0]      revision;
    logic             best_valid;
    logic [63:0]      best_key;
    logic [31:0]      best_pri;
    logic [63:0]      best_fp;
  } table_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             mode = MODE_UPSERT;
  logic [63:0]      key = '0;
  logic             enabled = 1'b0;
  logic [31:0]      priority_req = '0;
  logic [63:0]      fingerprint = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic             found;
  logic             found_enabled;
  logic [31:0]      found_priority;
  logic [63:0]      found_fingerprint;
  logic [CNT_W-1:0] entry_count;
  logic [63:0]      revision;
  logic             best_valid;
  logic [63:0]      best_key;
  logic [31:0]      best_priority;
  logic [63:0]      best_fingerprint;

  keyed_table_upsert_best_select_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .key               (key),
    .enabled           (enabled),
    .priority_req      (priority_req),
    .fingerprint       (fingerprint),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .found             (found),
    .found_enabled     (found_enabled),
    .found_priority    (found_priority),
    .found_fingerprint (found_fingerprint),
    .entry_count       (entry_count),
    .revision          (revision),
    .best_valid        (best_valid),
    .best_key          (best_key),
    .best_priority     (best_priority),
    .best_fingerprint  (best_fingerprint)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the table
  logic [63:0] held_key [CAPACITY];
  logic        held_enabled [CAPACITY];
  logic [31:0] held_priority [CAPACITY];
  logic [63:0] held_fingerprint [CAPACITY];
  int          held_count = 0;
  logic [63:0] table_revision = 64'd1;

  table_op_t     pending_ops [$];
  table_result_t expected_results [$];
  logic [63:0]   key_pool [POOL_SIZE];
  table_op_t     op_on_bus;

  int ops_total = 0;
  int ops_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int quiet_cycles = 0;

  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t r;
    logic [63:0]   k;
    int            hit;
    int            best;
    bit            have_best;
    r = '{default: '0};
    k = op.key & KEY_MASK;
    hit = -1;
    best = 0;
    have_best = 1'b0;
    if (k != '0) begin
      for (int i = 0; i < held_count; i++) begin
        if (hit < 0 && held_key[i] == k) hit = i;
      end
    end
    if (op.mode == MODE_UPSERT) begin
      if (k == '0) begin
        r.status = ST_EMPTY;
      end else if (hit < 0 && held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_OK;
        if (hit < 0) begin
          hit = held_count;
          held_key[hit] = k;
          held_count++;
        end
        held_enabled[hit] = op.enabled;
        held_priority[hit] = op.pri;
        held_fingerprint[hit] = op.fp;
        if (table_revision != K_ONES) table_revision++;
      end
    end else begin
      r.status = ST_OK;
      if (hit >= 0) begin
        r.found = 1'b1;
        r.found_enabled = held_enabled[hit];
        r.found_pri = held_priority[hit];
        r.found_fp = held_fingerprint[hit];
      end
    end
    // Strict compares keep the earliest entry on an exact tie
    for (int i = 0; i < held_count; i++) begin
      if (held_enabled[i] && (!have_best || held_priority[i] > held_priority[best] ||
          (held_priority[i] == held_priority[best] &&
           held_fingerprint[i] > held_fingerprint[best]))) begin
        best = i;
        have_best = 1'b1;
      end
    end
    r.entry_count = held_count[CNT_W-1:0];
    r.revision = table_revision;
    if (have_best) begin
      r.best_valid = 1'b1;
      r.best_key = held_key[best];
      r.best_pri = held_priority[best];
      r.best_fp = held_fingerprint[best];
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3, 4, 5: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_fingerprint();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3, 4, 5: return 64'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  // Mostly short idles, a few long ones, with calm stretches of no idling
  function automatic int draw_idle(ref int calm_left, input int long_max);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    case ($urandom_range(0, 19))
      10, 11, 12, 13, 14, 15, 16: return $urandom_range(1, 3);
      17, 18:                     return $urandom_range(4, 10);
      19:                         return $urandom_range(20, long_max);
      default:                    return 0;
    endcase
  endfunction

  task automatic queue_op(input logic m, input logic [63:0] k, input logic en,
                          input logic [31:0] p, input logic [63:0] f);
    pending_ops.push_back('{mode: m, key: k, enabled: en, pri: p, fp: f});
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_ERR_LINES)
      $display("ERROR %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  // Driver: present queued operations, predict each one as its transaction completes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_table_op(op_on_bus));
        ops_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op_on_bus = pending_ops.pop_front();
          in_valid <= 1'b1;
          mode <= op_on_bus.mode;
          key <= op_on_bus.key;
          enabled <= op_on_bus.enabled;
          priority_req <= op_on_bus.pri;
          fingerprint <= op_on_bus.fp;
          send_gap = draw_idle(send_calm, 60);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : monitor
    table_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(status), 64'(want.status));
          check_field("found", 64'(found), 64'(want.found));
          check_field("found_enabled", 64'(found_enabled), 64'(want.found_enabled));
          check_field("found_priority", 64'(found_priority), 64'(want.found_pri));
          check_field("found_fingerprint", found_fingerprint, want.found_fp);
          check_field("entry_count", 64'(entry_count), 64'(want.entry_count));
          check_field("revision", revision, want.revision);
          check_field("best_valid", 64'(best_valid), 64'(want.best_valid));
          check_field("best_key", best_key, want.best_key);
          check_field("best_priority", 64'(best_priority), 64'(want.best_pri));
          check_field("best_fingerprint", best_fingerprint, want.best_fp);
        end
        results_seen++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) recv_stall = draw_idle(recv_calm, 80);
      end
    end
  end

  // Watchdog: give up when no transaction completes on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int          sel;
    logic [63:0] k;

    key_pool[0] = K_ONES;
    key_pool[1] = K_ONE;
    key_pool[2] = K_TOP;
    key_pool[3] = K_CFG;
    for (int i = 4; i < POOL_SIZE; i++) begin
      do k = rand64(); while (k == '0);
      key_pool[i] = k;
    end

    // Empty table, empty key, exact ties, priority ties and updates
    queue_op(MODE_FIND, 64'h41, 1'b0, '0, '0);
    queue_op(MODE_UPSERT, '0, 1'b1, '1, '1);
    queue_op(MODE_FIND, '0, 1'b1, '1, '1);
    queue_op(MODE_UPSERT, K_ONES, 1'b1, '1, '1);
    queue_op(MODE_UPSERT, K_ONE, 1'b1, '1, '1);
    queue_op(MODE_UPSERT, K_TOP, 1'b0, '1, '1);
    queue_op(MODE_UPSERT, K_CFG, 1'b1, '1, '0);
    queue_op(MODE_UPSERT, K_ONES, 1'b1, '0, '0);
    queue_op(MODE_FIND, K_ONES, 1'b0, '0, '0);
    queue_op(MODE_FIND, K_TOP, 1'b0, '0, '0);
    queue_op(MODE_FIND, 64'h1234, 1'b0, '0, '0);
    queue_op(MODE_UPSERT, K_ONE, 1'b0, '1, '1);
    queue_op(MODE_UPSERT, K_TOP, 1'b1, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_op(MODE_UPSERT, K_CFG, 1'b0, 32'h5555_5555, 64'h5555_5555_5555_5555);
    queue_op(MODE_FIND, K_CFG, 1'b0, '0, '0);
    queue_op(MODE_UPSERT, K_TOP, 1'b0, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_op(MODE_UPSERT, K_ONES, 1'b0, '0, '0);
    queue_op(MODE_FIND, K_ONE, 1'b0, '0, '0);
    queue_op(MODE_UPSERT, 64'h5555_5555_5555_5555, 1'b1, '0, '1);

    // Mostly pool keys so entries get updated and found; the pool outgrows the table
    for (int n = 0; n < RANDOM_OPS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) k = '0;
      else if (sel < 15) k = rand64();
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_op(($urandom_range(0, 99) < 40) ? MODE_FIND : MODE_UPSERT, k,
               1'($urandom_range(0, 1)), pick_priority(), pick_fingerprint());
    end
    ops_total = pending_ops.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (ops_accepted < ops_total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
